// ----- src/itcf_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the tilt filter.
// Used by itcf_ctrl, itcf_dpath and imu_tilt_complementary_filter.
`timescale 1ns / 1ps

package itcf_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 25;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_KEEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_HIGH = 2'd3;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GYRO_GAIN_RST      = 16'd10230;
  localparam logic [CFG_W-1:0]  BLEND_KEEP_RST     = 17'd64225;
  localparam logic [CFG_W-1:0]  MAGNITUDE_LOW_RST  = 17'd8192;
  localparam logic [CFG_W-1:0]  MAGNITUDE_HIGH_RST = 17'd32768;

  // Unity weight in Q16.
  localparam logic [CFG_W-1:0] KEEP_ONE = 17'd65536;

  // Default parameter values.
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ANGLE_FRAC_BITS_DEF   = 16;

  // CORDIC constants. The angle accumulator holds radians in Q30 and never
  // exceeds pi plus the sum of the table, so 34 bits carry it.
  localparam int ATAN_LEN = 24;
  localparam int ZW       = 34;
  localparam int XW       = 35;
  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic [29:0] RAD2DEG_Q24 = 30'd961263669;

  // Shared multiplier operand and product widths.
  localparam int MW  = 31;
  localparam int PW  = 2 * MW;
  localparam int ACW = 64;

  typedef enum logic [2:0] {
    MUL_GYRO_X,
    MUL_GYRO_Y,
    MUL_Z_HI,
    MUL_Z_LO,
    MUL_KEEP,
    MUL_WEIGHT
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SHIFT_ADD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_GYRO_PITCH,
    UPD_GYRO_ROLL,
    UPD_ACC_ANGLE,
    UPD_BLEND
  } upd_e;

  typedef struct packed {
    logic     load_in;
    logic     set_applied;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    upd_e     upd;
    logic     cordic_init;
    logic     cordic_step;
    logic     axis_roll;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic applied;
    logic cordic_last;
  } status_t;

  // atan(2^-i) in radians, Q30.
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/itcf_ctrl.sv -----
// Sequencer of the tilt filter: walks the datapath through the gyro step,
// two CORDIC passes and the blends for an in-window sample. Depends on itcf_pkg.
`timescale 1ns / 1ps

module itcf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  itcf_pkg::status_t status_i,
  output itcf_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GYRO_P,
    ST_GYRO_R,
    ST_GYRO_FIN,
    ST_CORDIC_INIT,
    ST_CORDIC_RUN,
    ST_DEG_HI,
    ST_DEG_LO,
    ST_DEG_SUM,
    ST_DEG_ROUND,
    ST_BLEND_KEEP,
    ST_BLEND_ACC,
    ST_BLEND_SUM,
    ST_BLEND_UPD,
    ST_OUTPUT
  } state_e;

  state_e state_q;
  logic   axis_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o             = '0;
    cmd_o.mul_sel     = itcf_pkg::MUL_GYRO_X;
    cmd_o.acc_op      = itcf_pkg::ACC_HOLD;
    cmd_o.upd         = itcf_pkg::UPD_NONE;
    cmd_o.axis_roll   = axis_q;
    case (state_q)
      ST_IDLE:        cmd_o.load_in = in_valid_i;
      ST_GYRO_P: begin
        cmd_o.mul_sel     = itcf_pkg::MUL_GYRO_X;
        cmd_o.set_applied = 1'b1;
      end
      ST_GYRO_R: begin
        cmd_o.mul_sel = itcf_pkg::MUL_GYRO_Y;
        cmd_o.upd     = itcf_pkg::UPD_GYRO_PITCH;
      end
      ST_GYRO_FIN:    cmd_o.upd = itcf_pkg::UPD_GYRO_ROLL;
      ST_CORDIC_INIT: cmd_o.cordic_init = 1'b1;
      ST_CORDIC_RUN:  cmd_o.cordic_step = 1'b1;
      ST_DEG_HI:      cmd_o.mul_sel = itcf_pkg::MUL_Z_HI;
      ST_DEG_LO: begin
        cmd_o.mul_sel = itcf_pkg::MUL_Z_LO;
        cmd_o.acc_op  = itcf_pkg::ACC_LOAD;
      end
      ST_DEG_SUM:     cmd_o.acc_op = itcf_pkg::ACC_SHIFT_ADD;
      ST_DEG_ROUND:   cmd_o.upd = itcf_pkg::UPD_ACC_ANGLE;
      ST_BLEND_KEEP:  cmd_o.mul_sel = itcf_pkg::MUL_KEEP;
      ST_BLEND_ACC: begin
        cmd_o.mul_sel = itcf_pkg::MUL_WEIGHT;
        cmd_o.acc_op  = itcf_pkg::ACC_LOAD;
      end
      ST_BLEND_SUM:   cmd_o.acc_op = itcf_pkg::ACC_ADD;
      ST_BLEND_UPD:   cmd_o.upd = itcf_pkg::UPD_BLEND;
      ST_OUTPUT:      cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            axis_q  <= 1'b0;
            state_q <= ST_GYRO_P;
          end
        end
        ST_GYRO_P:   state_q <= ST_GYRO_R;
        ST_GYRO_R:   state_q <= ST_GYRO_FIN;
        ST_GYRO_FIN: state_q <= status_i.applied ? ST_CORDIC_INIT : ST_OUTPUT;
        ST_CORDIC_INIT: state_q <= ST_CORDIC_RUN;
        ST_CORDIC_RUN: begin
          if (status_i.cordic_last) begin
            state_q <= ST_DEG_HI;
          end
        end
        ST_DEG_HI:     state_q <= ST_DEG_LO;
        ST_DEG_LO:     state_q <= ST_DEG_SUM;
        ST_DEG_SUM:    state_q <= ST_DEG_ROUND;
        ST_DEG_ROUND:  state_q <= ST_BLEND_KEEP;
        ST_BLEND_KEEP: state_q <= ST_BLEND_ACC;
        ST_BLEND_ACC:  state_q <= ST_BLEND_SUM;
        ST_BLEND_SUM:  state_q <= ST_BLEND_UPD;
        ST_BLEND_UPD: begin
          // Pitch is blended first, then the same sequence runs for roll.
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_CORDIC_INIT;
          end else begin
            state_q <= ST_OUTPUT;
          end
        end
        ST_OUTPUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/itcf_dpath.sv -----
// Datapath of the tilt filter: configuration registers, angle state, an
// iterative CORDIC, one shared multiplier with accumulator, output registers.
// Depends on itcf_pkg.
`timescale 1ns / 1ps

module itcf_dpath #(
  parameter int CORDIC_ITERATIONS = itcf_pkg::CORDIC_ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS   = itcf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [itcf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [itcf_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] accel_z_i,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] rate_x_i,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] rate_y_i,
  input  itcf_pkg::cmd_t                       cmd_i,
  output itcf_pkg::status_t                    status_o,
  output logic signed [itcf_pkg::OUT_W-1:0]    pitch_out_o,
  output logic signed [itcf_pkg::OUT_W-1:0]    roll_out_o,
  output logic                                 accel_applied_o
);

  localparam int NI  = (CORDIC_ITERATIONS > itcf_pkg::ATAN_LEN) ?
                       itcf_pkg::ATAN_LEN : CORDIC_ITERATIONS;
  localparam int IW  = (NI > 1) ? $clog2(NI) : 1;
  localparam int AW  = ANGLE_FRAC_BITS + 9;
  localparam int EW  = ANGLE_FRAC_BITS + 10;
  localparam int GS  = 24 - ANGLE_FRAC_BITS;
  localparam int RS  = 54 - ANGLE_FRAC_BITS;
  localparam int SW  = itcf_pkg::SAMPLE_W;
  localparam int CW  = itcf_pkg::CFG_W;
  localparam int XW  = itcf_pkg::XW;
  localparam int ZW  = itcf_pkg::ZW;
  localparam int MW  = itcf_pkg::MW;
  localparam int PW  = itcf_pkg::PW;
  localparam int ACW = itcf_pkg::ACW;
  localparam int ZLO = 17;

  localparam logic signed [ACW-1:0] LIM       = 64'sd180 <<< ANGLE_FRAC_BITS;
  localparam logic signed [ACW-1:0] GYRO_HALF = 64'sd1 <<< (GS - 1);
  localparam logic signed [ACW-1:0] DEG_HALF  = 64'sd1 <<< (RS - 1);
  localparam logic signed [ACW-1:0] Q16_HALF  = 64'sd32768;
  localparam logic [IW-1:0]         LAST_ITER = IW'(NI - 1);

  // Configuration registers.
  logic [itcf_pkg::GAIN_W-1:0] gain_q;
  logic [CW-1:0]               keep_q;
  logic [CW-1:0]               mag_low_q;
  logic [CW-1:0]               mag_high_q;

  // Captured sample.
  logic signed [SW-1:0] ax_q, ay_q, az_q, rx_q, ry_q;

  // Filter state and per-item flags.
  logic signed [AW-1:0] pitch_q, roll_q;
  logic                 applied_q;
  logic signed [EW-1:0] acc_angle_q;

  // CORDIC unit.
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [IW-1:0]        iter_q;
  logic                 special_q;
  logic                 special_neg_q;

  // Shared multiplier and accumulator.
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod_q;
  logic signed [ACW-1:0] acc_q;

  logic [CW-1:0]          keep_eff;
  logic [CW-1:0]          weight;
  logic [CW-1:0]          mag;
  logic                   mag_in_window;
  logic signed [ACW-1:0]  prod_ext;
  logic signed [ACW-1:0]  gyro_delta;
  logic signed [ACW-1:0]  deg_round;
  logic signed [ACW-1:0]  blend_round;
  logic signed [ACW-1:0]  pitch_out_ext, roll_out_ext;

  function automatic logic signed [AW-1:0] sat_angle(input logic signed [ACW-1:0] v);
    if (v > LIM) begin
      return AW'(LIM);
    end
    if (v < -LIM) begin
      return AW'(-LIM);
    end
    return AW'(v);
  endfunction

  function automatic logic [CW-1:0] abs_sample(input logic signed [SW-1:0] s);
    logic signed [CW-1:0] w;
    w = CW'(s);
    return w[CW-1] ? CW'(-w) : CW'(w);
  endfunction

  assign keep_eff = (keep_q > itcf_pkg::KEEP_ONE) ? itcf_pkg::KEEP_ONE : keep_q;
  assign weight   = itcf_pkg::KEEP_ONE - keep_eff;

  assign mag = abs_sample(ax_q) + abs_sample(ay_q) + abs_sample(az_q);
  assign mag_in_window = (mag > mag_low_q) && (mag < mag_high_q);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      itcf_pkg::MUL_GYRO_X: begin
        mul_a = MW'(rx_q);
        mul_b = MW'($signed({1'b0, gain_q}));
      end
      itcf_pkg::MUL_GYRO_Y: begin
        mul_a = MW'(ry_q);
        mul_b = MW'($signed({1'b0, gain_q}));
      end
      itcf_pkg::MUL_Z_HI: begin
        mul_a = MW'(z_q >>> ZLO);
        mul_b = MW'($signed({1'b0, itcf_pkg::RAD2DEG_Q24}));
      end
      itcf_pkg::MUL_Z_LO: begin
        mul_a = MW'($signed({1'b0, z_q[ZLO-1:0]}));
        mul_b = MW'($signed({1'b0, itcf_pkg::RAD2DEG_Q24}));
      end
      itcf_pkg::MUL_KEEP: begin
        mul_a = cmd_i.axis_roll ? MW'(roll_q) : MW'(pitch_q);
        mul_b = MW'($signed({1'b0, keep_eff}));
      end
      itcf_pkg::MUL_WEIGHT: begin
        mul_a = MW'(acc_angle_q);
        mul_b = MW'($signed({1'b0, weight}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext    = ACW'(prod_q);
  assign gyro_delta  = (prod_ext + GYRO_HALF) >>> GS;
  assign deg_round   = (acc_q + DEG_HALF) >>> RS;
  assign blend_round = (acc_q + Q16_HALF) >>> 16;

  // Configuration registers and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= itcf_pkg::GYRO_GAIN_RST;
      keep_q     <= itcf_pkg::BLEND_KEEP_RST;
      mag_low_q  <= itcf_pkg::MAGNITUDE_LOW_RST;
      mag_high_q <= itcf_pkg::MAGNITUDE_HIGH_RST;
      pitch_q    <= '0;
      roll_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          itcf_pkg::REG_GYRO_GAIN:      gain_q <= cfg_data_i[itcf_pkg::GAIN_W-1:0];
          itcf_pkg::REG_BLEND_KEEP:     keep_q <= cfg_data_i;
          itcf_pkg::REG_MAGNITUDE_LOW:  mag_low_q <= cfg_data_i;
          itcf_pkg::REG_MAGNITUDE_HIGH: mag_high_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.upd)
        itcf_pkg::UPD_GYRO_PITCH: pitch_q <= sat_angle(ACW'(pitch_q) + gyro_delta);
        itcf_pkg::UPD_GYRO_ROLL:  roll_q <= sat_angle(ACW'(roll_q) - gyro_delta);
        itcf_pkg::UPD_BLEND: begin
          if (cmd_i.axis_roll) begin
            roll_q <= sat_angle(blend_round);
          end else begin
            pitch_q <= sat_angle(blend_round);
          end
        end
        default: ;
      endcase
    end
  end

  // Sample capture, CORDIC, multiplier and output registers.
  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] num, den;
    num = cmd_i.axis_roll ? CW'(ax_q) : CW'(ay_q);
    den = CW'(az_q);

    if (cmd_i.load_in) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      rx_q <= rate_x_i;
      ry_q <= rate_y_i;
    end

    if (cmd_i.set_applied) begin
      applied_q <= mag_in_window;
    end

    prod_q <= mul_a * mul_b;

    case (cmd_i.acc_op)
      itcf_pkg::ACC_LOAD:      acc_q <= prod_ext;
      itcf_pkg::ACC_SHIFT_ADD: acc_q <= (acc_q <<< ZLO) + prod_ext;
      itcf_pkg::ACC_ADD:       acc_q <= acc_q + prod_ext;
      default: ;
    endcase

    if (cmd_i.upd == itcf_pkg::UPD_ACC_ANGLE) begin
      // A zero numerator gives zero, or 180 degrees for a negative denominator.
      if (special_q) begin
        acc_angle_q <= special_neg_q ? EW'(LIM) : '0;
      end else begin
        acc_angle_q <= EW'(deg_round);
      end
    end

    if (cmd_i.cordic_init) begin
      // A negative denominator is folded into the right half plane and the
      // angle starts from plus or minus pi.
      special_q     <= (num == '0);
      special_neg_q <= den[CW-1];
      iter_q        <= '0;
      if (den[CW-1]) begin
        x_q <= XW'(-den) <<< 16;
        y_q <= XW'(-num) <<< 16;
        z_q <= (num > 0) ? itcf_pkg::PI_Q30 : -itcf_pkg::PI_Q30;
      end else begin
        x_q <= XW'(den) <<< 16;
        y_q <= XW'(num) <<< 16;
        z_q <= '0;
      end
    end else if (cmd_i.cordic_step) begin
      iter_q <= IW'(iter_q + 1'b1);
      if (!y_q[XW-1]) begin
        x_q <= x_q + (y_q >>> iter_q);
        y_q <= y_q - (x_q >>> iter_q);
        z_q <= z_q + ZW'($signed({1'b0, itcf_pkg::atan_q30(5'(iter_q))}));
      end else begin
        x_q <= x_q - (y_q >>> iter_q);
        y_q <= y_q + (x_q >>> iter_q);
        z_q <= z_q - ZW'($signed({1'b0, itcf_pkg::atan_q30(5'(iter_q))}));
      end
    end

    if (cmd_i.load_out) begin
      pitch_out_o     <= pitch_out_ext[itcf_pkg::OUT_W-1:0];
      roll_out_o      <= roll_out_ext[itcf_pkg::OUT_W-1:0];
      accel_applied_o <= applied_q;
    end
  end

  assign pitch_out_ext = ACW'(pitch_q);
  assign roll_out_ext  = ACW'(roll_q);

  assign status_o.applied     = applied_q;
  assign status_o.cordic_last = (iter_q == LAST_ITER);

endmodule

// ----- src/imu_tilt_complementary_filter.sv -----
// Top level of the pitch and roll complementary filter.
// Instantiates itcf_ctrl and itcf_dpath; uses itcf_pkg.
//
//   Channel  Signals                                        Direction
//   -------  ---------------------------------------------  ---------
//   in       in_valid_i, in_stall_o, accel_*_i, rate_*_i    sink
//   out      out_valid_o, out_stall_i, pitch/roll_out_o,     source
//            accel_applied_o
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i              write only
//
// A sample outside the magnitude window skips the CORDIC and the blends. A
// sample inside it runs the single shared CORDIC unit, its iteration count
// capped at 24, once for pitch and once for roll. No new sample is accepted
// until the sequencer is back in idle.
// Reset clears both angles and loads the register defaults.
// The result waits in an output register; a stalled output holds the
// sequencer only at the point where the next result would be written.
`timescale 1ns / 1ps

module imu_tilt_complementary_filter #(
  parameter int CORDIC_ITERATIONS = itcf_pkg::CORDIC_ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS   = itcf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [itcf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [itcf_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] accel_z_i,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] rate_x_i,
  input  logic signed [itcf_pkg::SAMPLE_W-1:0] rate_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [itcf_pkg::OUT_W-1:0]    pitch_out_o,
  output logic signed [itcf_pkg::OUT_W-1:0]    roll_out_o,
  output logic                                 accel_applied_o
);

  itcf_pkg::cmd_t    cmd;
  itcf_pkg::status_t status;

  itcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  itcf_dpath #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
    .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .rate_x_i        (rate_x_i),
    .rate_y_i        (rate_y_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .pitch_out_o     (pitch_out_o),
    .roll_out_o      (roll_out_o),
    .accel_applied_o (accel_applied_o)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for imu_tilt_complementary_filter: a queue-fed driver, a result monitor
// and an in-bench pitch/roll predictor that checks every output transaction field by field.
// Depends on itcf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int CORDIC_N = itcf_pkg::CORDIC_ITERATIONS_DEF;
  localparam int FRAC = itcf_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int SW = itcf_pkg::SAMPLE_W;
  localparam int OW = itcf_pkg::OUT_W;
  localparam int CW = itcf_pkg::CFG_W;
  localparam int CORDIC_STEPS = (CORDIC_N > 24) ? 24 : CORDIC_N;
  localparam longint ANGLE_LIM = longint'(180) <<< FRAC;
  localparam int GYRO_SHIFT = 24 - FRAC;
  localparam int ATAN_SHIFT = 54 - FRAC;
  localparam longint PI_RAD30 = 64'd3373259426;
  localparam longint DEG_Q24 = 64'd961263669;
  localparam int PHASES = 9;
  localparam int RANDOM_PER_PHASE = 215;
  localparam int RUN_LIMIT_NS = 15_000_000;

  typedef struct packed {
    logic signed [SW-1:0] ax;
    logic signed [SW-1:0] ay;
    logic signed [SW-1:0] az;
    logic signed [SW-1:0] gx;
    logic signed [SW-1:0] gy;
  } sample_t;

  typedef struct packed {
    logic [OW-1:0] pitch;
    logic [OW-1:0] roll;
    logic          applied;
  } tilt_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 cfg_we = 1'b0;
  logic [itcf_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CW-1:0]                        cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [SW-1:0]                 accel_x = '0;
  logic signed [SW-1:0]                 accel_y = '0;
  logic signed [SW-1:0]                 accel_z = '0;
  logic signed [SW-1:0]                 rate_x = '0;
  logic signed [SW-1:0]                 rate_y = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [OW-1:0]                 pitch_out;
  logic signed [OW-1:0]                 roll_out;
  logic                                 accel_applied;

  // Predictor state and its copy of the registers, starting at the reset values.
  longint pitch_ang = 0;
  longint roll_ang = 0;
  longint gain_cfg = 10230;
  longint keep_cfg = 64225;
  longint low_cfg = 8192;
  longint high_cfg = 32768;

  sample_t     sample_q[$];
  tilt_t       tilt_q[$];
  sample_t     drv_item;
  tilt_t       want;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int          samples_queued = 0;
  int          results_checked = 0;
  int          err_count = 0;

  imu_tilt_complementary_filter #(
    .CORDIC_ITERATIONS(CORDIC_N),
    .ANGLE_FRAC_BITS  (FRAC)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .accel_x_i      (accel_x),
    .accel_y_i      (accel_y),
    .accel_z_i      (accel_z),
    .rate_x_i       (rate_x),
    .rate_y_i       (rate_y),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pitch_out_o    (pitch_out),
    .roll_out_o     (roll_out),
    .accel_applied_o(accel_applied)
  );

  always #6 clk = ~clk;

  // atan(2^-i) in radians, Q30.
  function automatic longint atan_entry(input int i);
    longint v;
    case (i)
      0:       v = 'h3243F6A8;
      1:       v = 'h1DAC6705;
      2:       v = 'h0FADBAFC;
      3:       v = 'h07F56EA6;
      4:       v = 'h03FEAB76;
      5:       v = 'h01FFD55B;
      6:       v = 'h00FFFAAA;
      7:       v = 'h007FFF55;
      8:       v = 'h003FFFEA;
      9:       v = 'h001FFFFD;
      10:      v = 'h000FFFFF;
      11:      v = 'h0007FFFF;
      12:      v = 'h0003FFFF;
      13:      v = 'h0001FFFF;
      14:      v = 'h0000FFFF;
      15:      v = 'h00007FFF;
      16:      v = 'h00003FFF;
      17:      v = 'h00001FFF;
      18:      v = 'h00000FFF;
      19:      v = 'h000007FF;
      20:      v = 'h000003FF;
      21:      v = 'h000001FF;
      22:      v = 'h000000FF;
      23:      v = 'h0000007F;
      default: v = 0;
    endcase
    return v;
  endfunction

  function automatic longint clamp_angle(input longint v);
    if (v > ANGLE_LIM) return ANGLE_LIM;
    if (v < -ANGLE_LIM) return -ANGLE_LIM;
    return v;
  endfunction

  // Round half toward +infinity, then drop s fraction bits.
  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint cordic_atan2(input longint num_in, input longint den_in);
    longint num, den, x, y, z, dx, dy;
    int i;
    num = num_in;
    den = den_in;
    z = 0;
    if (num == 0) return (den < 0) ? ANGLE_LIM : 0;
    // Rotate a left half-plane vector by half a turn before the vectoring pass.
    if (den < 0) begin
      z = (num > 0) ? PI_RAD30 : -PI_RAD30;
      num = -num;
      den = -den;
    end
    x = den <<< 16;
    y = num <<< 16;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_entry(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_entry(i);
      end
    end
    return round_half_up(z * DEG_Q24, ATAN_SHIFT);
  endfunction

  function automatic longint blend_angle(input longint ang, input longint acc,
                                         input longint kw);
    return clamp_angle((kw * ang + (longint'(65536) - kw) * acc + 32768) >>> 16);
  endfunction

  // Advances the tilt state by one sample and returns the result it should produce.
  function automatic tilt_t advance_tilt(input sample_t s);
    tilt_t  r;
    longint ax, ay, az, mag, kw;
    ax = longint'($signed(s.ax));
    ay = longint'($signed(s.ay));
    az = longint'($signed(s.az));
    pitch_ang = clamp_angle(pitch_ang
                            + round_half_up(longint'($signed(s.gx)) * gain_cfg, GYRO_SHIFT));
    roll_ang = clamp_angle(roll_ang
                           - round_half_up(longint'($signed(s.gy)) * gain_cfg, GYRO_SHIFT));
    mag = ((ax < 0) ? -ax : ax) + ((ay < 0) ? -ay : ay) + ((az < 0) ? -az : az);
    r.applied = (mag > low_cfg) && (mag < high_cfg);
    if (r.applied) begin
      kw = (keep_cfg > 65536) ? 65536 : keep_cfg;
      pitch_ang = blend_angle(pitch_ang, cordic_atan2(ay, az), kw);
      roll_ang = blend_angle(roll_ang, cordic_atan2(ax, az), kw);
    end
    r.pitch = pitch_ang[OW-1:0];
    r.roll = roll_ang[OW-1:0];
    return r;
  endfunction

  function automatic int rnd_span(input int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  task automatic push_sample(input int ax, input int ay, input int az, input int gx,
                             input int gy);
    sample_t s;
    s.ax = 16'(ax);
    s.ay = 16'(ay);
    s.az = 16'(az);
    s.gx = 16'(gx);
    s.gy = 16'(gy);
    sample_q.push_back(s);
    samples_queued++;
  endtask

  task automatic program_regs(input int unsigned gain, input int unsigned keep,
                              input int unsigned lo, input int unsigned hi);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= itcf_pkg::REG_GYRO_GAIN;
    cfg_data <= gain[CW-1:0];
    @(posedge clk);
    cfg_index <= itcf_pkg::REG_BLEND_KEEP;
    cfg_data <= keep[CW-1:0];
    @(posedge clk);
    cfg_index <= itcf_pkg::REG_MAGNITUDE_LOW;
    cfg_data <= lo[CW-1:0];
    @(posedge clk);
    cfg_index <= itcf_pkg::REG_MAGNITUDE_HIGH;
    cfg_data <= hi[CW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_cfg = longint'(gain & 32'hFFFF);
    keep_cfg = longint'(keep & 32'h1FFFF);
    low_cfg = longint'(lo & 32'h1FFFF);
    high_cfg = longint'(hi & 32'h1FFFF);
  endtask

  task automatic flag(input string what);
    err_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Driver: a stalled transaction holds its payload; a new one is offered at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tilt_q.push_back(advance_tilt(drv_item));
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = sample_q.pop_front();
          accel_x <= drv_item.ax;
          accel_y <= drv_item.ay;
          accel_z <= drv_item.az;
          rate_x <= drv_item.gx;
          rate_y <= drv_item.gy;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (tilt_q.size() == 0) begin
          flag("result transaction with no sample pending");
        end else begin
          want = tilt_q.pop_front();
          results_checked++;
          if (pitch_out !== want.pitch)
            flag($sformatf("pitch %0d, expected %0d", pitch_out, $signed(want.pitch)));
          if (roll_out !== want.roll)
            flag($sformatf("roll %0d, expected %0d", roll_out, $signed(want.roll)));
          if (accel_applied !== want.applied)
            flag($sformatf("accel_applied %b, expected %b", accel_applied, want.applied));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int phase, kind, rk, t, a, b, c;
    int ax_v, ay_v, az_v, gx_v, gy_v;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        while (results_checked != samples_queued) @(negedge clk);
        repeat (8) @(negedge clk);
        case (phase)
          1: program_regs(65535, 0, 0, 98304);
          2: program_regs(0, 65536, 0, 131071);
          3: program_regs($urandom_range(65535), 131071, 0, 98304);
          4: program_regs(10230, 64225, 8192, 32768);
          7: program_regs($urandom_range(65535), $urandom_range(65536), 98304, 0);
          8: program_regs(1, 65535, 8191, 32769);
          default: program_regs($urandom_range(65535), $urandom_range(65536),
                                $urandom_range(20000), $urandom_range(98304, 20000));
        endcase
      end
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 62;
        end
        default: begin
          send_idle_pct = 18;
          stall_pct = 18;
        end
      endcase

      if (phase == 0) begin
        push_sample(0, 0, 0, 0, 0);
        push_sample(-32768, -32768, -32768, -32768, -32768);
        push_sample(32767, 32767, 32767, 32767, 32767);
        // Zero numerator against a negative, a positive and a zero denominator.
        push_sample(0, 0, -16000, 1, -1);
        push_sample(0, 0, 16000, 0, 0);
        push_sample(16000, 0, 0, 0, 0);
        push_sample(0, -16000, 0, 0, 0);
        // Negative denominator with either sign of numerator.
        push_sample(5000, 8000, -9000, 100, -100);
        push_sample(-5000, -8000, -9000, -100, 100);
        // Magnitude on and just inside each bound of the default window.
        push_sample(4096, 4096, 0, 0, 0);
        push_sample(4096, 4097, 0, 0, 0);
        push_sample(10000, -10000, 12768, 0, 0);
        push_sample(10000, -10000, -12767, 0, 0);
        push_sample(-32768, 0, 0, 0, 0);
      end else if (phase == 1) begin
        // Full-scale rates at maximum gain drive both angles into saturation.
        repeat (3) push_sample(0, 0, 0, 32767, -32768);
        repeat (3) push_sample(0, 0, 0, -32768, 32767);
      end

      repeat (RANDOM_PER_PHASE) begin
        kind = $urandom_range(99);
        if (kind < 15) begin
          ax_v = rnd_span(32768);
          ay_v = rnd_span(32768);
          az_v = rnd_span(32768);
        end else if (kind < 65) begin
          ax_v = rnd_span(14000);
          ay_v = rnd_span(14000);
          az_v = rnd_span(14000);
          if (kind >= 50) begin
            t = $urandom_range(2);
            if (t == 0) ax_v = 0;
            else if (t == 1) ay_v = 0;
            else az_v = 0;
            if (kind < 58) begin
              if (t == 0) ay_v = 0;
              else if (t == 1) az_v = 0;
              else ax_v = 0;
            end
          end
        end else if (kind < 80) begin
          // Mostly gravity along one axis.
          ax_v = rnd_span(1500);
          ay_v = rnd_span(1500);
          az_v = rnd_span(1500);
          c = 16384 + rnd_span(2000);
          if ($urandom_range(1) != 0) c = -c;
          t = $urandom_range(2);
          if (t == 0) ax_v = c;
          else if (t == 1) ay_v = c;
          else az_v = c;
        end else begin
          // Magnitude within one count of a window bound.
          t = (($urandom_range(1) != 0) ? int'(low_cfg) : int'(high_cfg)) + rnd_span(1);
          if (t < 0) t = 0;
          if (t > 98301) t = 98301;
          a = $urandom_range((t > 32767) ? 32767 : t, (t > 65534) ? t - 65534 : 0);
          t = t - a;
          b = $urandom_range((t > 32767) ? 32767 : t, (t > 32767) ? t - 32767 : 0);
          c = t - b;
          ax_v = ($urandom_range(1) != 0) ? -a : a;
          ay_v = ($urandom_range(1) != 0) ? -b : b;
          az_v = ($urandom_range(1) != 0) ? -c : c;
        end
        rk = $urandom_range(9);
        if (kind < 15 || rk == 7 || rk == 8) begin
          gx_v = rnd_span(32768);
          gy_v = rnd_span(32768);
        end else if (rk == 9) begin
          gx_v = ($urandom_range(1) != 0) ? 32767 : -32768;
          gy_v = ($urandom_range(1) != 0) ? 32767 : -32768;
        end else begin
          gx_v = rnd_span(3000);
          gy_v = rnd_span(3000);
        end
        push_sample(ax_v, ay_v, az_v, gx_v, gy_v);
      end
    end

    while (results_checked != samples_queued) @(negedge clk);
    repeat (80) @(negedge clk);
    if (tilt_q.size() != 0) flag("expected results left over at the end");
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: errors");
    $finish;
  end

endmodule
